// File: rtl/acrms_pkg.sv
// ----------------------------------------------------------------------------
// AC RMS estimator package
// Shared widths, register indexes, reset values and the run record type.
// ----------------------------------------------------------------------------
package acrms_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int SMP_W     = 16;
    localparam int COEF_W    = 16;
    localparam int GAIN_W    = 18;
    localparam int OUT_W     = 24;
    localparam int CNT_OUT_W = 16;
    localparam int Y_W       = 32;
    localparam int XSQ_W     = 2 * SMP_W;
    localparam int YSQ_W     = 2 * Y_W;
    localparam int YSQ_R_W   = YSQ_W - 24;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_N = $clog2(MAX_SAMPLES);
    localparam int S_W   = XSQ_W + LOG_N;
    localparam int SY_W  = YSQ_R_W + LOG_N;

    localparam int DV_W = ((S_W + 17) / 2) * 2;
    localparam int RT_W = DV_W / 2;
    localparam int CT_W = $clog2(DV_W);

    localparam int PROD_W = OUT_W + GAIN_W;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING_COEFF = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_AC_GAIN         = 1'b1;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd1966;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd65536;

    typedef struct packed {
        logic [S_W-1:0]   s;
        logic [SY_W-1:0]  sy;
        logic [CNT_W-1:0] n;
    } t_run;

endpackage

// File: rtl/acrms_front.sv
// ----------------------------------------------------------------------------
// AC RMS estimator front end
// Per-sample smoother, squaring and energy accumulation; hands finished runs
// to the run queue.
// ----------------------------------------------------------------------------
module acrms_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [acrms_pkg::SMP_W-1:0]         i_sample,
    input  logic                                i_last_sample,
    input  logic [acrms_pkg::COEF_W-1:0]        i_coeff,
    input  logic [acrms_pkg::QCNT_W-1:0]        i_q_count,
    output logic                                o_full,
    output logic                                o_q_push,
    output acrms_pkg::t_run                     o_q_data
);

    logic                               w_accept;
    logic [31:0]                        w_cx;
    logic [16:0]                        w_cinv;
    logic [48:0]                        w_cy;
    logic [49:0]                        w_sum;
    logic [acrms_pkg::Y_W-1:0]          w_y_next;
    logic [acrms_pkg::CNT_W-1:0]        w_cnt_inc;
    logic                               w_end;
    logic [acrms_pkg::QCNT_W:0]         w_inflight;
    logic [acrms_pkg::YSQ_W:0]          w_ysq_tmp;
    logic [acrms_pkg::YSQ_R_W-1:0]      w_ysq_rnd;
    logic [acrms_pkg::S_W-1:0]          n_s;
    logic [acrms_pkg::SY_W-1:0]         n_sy;

    logic                               r_first;
    logic [acrms_pkg::CNT_W-1:0]        r_cnt;
    logic [acrms_pkg::Y_W-1:0]          r_y;

    logic                               r_p1_valid;
    logic                               r_p1_end;
    logic [acrms_pkg::SMP_W-1:0]        r_p1_x;
    logic [acrms_pkg::CNT_W-1:0]        r_p1_n;

    logic                               r_p2_valid;
    logic                               r_p2_end;
    logic [acrms_pkg::XSQ_W-1:0]        r_p2_xsq;
    logic [acrms_pkg::YSQ_W-1:0]        r_p2_ysq;
    logic [acrms_pkg::CNT_W-1:0]        r_p2_n;

    logic [acrms_pkg::S_W-1:0]          r_s;
    logic [acrms_pkg::SY_W-1:0]         r_sy;

    // room is reserved for run ends still in the pipeline
    assign w_inflight = {1'b0, i_q_count}
                      + (acrms_pkg::QCNT_W+1)'(r_p1_valid && r_p1_end)
                      + (acrms_pkg::QCNT_W+1)'(r_p2_valid && r_p2_end);
    assign o_full   = (w_inflight >= (acrms_pkg::QCNT_W+1)'(acrms_pkg::QDEPTH));
    assign w_accept = i_push && !o_full;

    assign w_cx      = i_coeff * i_sample;
    assign w_cinv    = 17'(17'd65536 - {1'b0, i_coeff});
    assign w_cy      = w_cinv * r_y;
    assign w_sum     = {2'b00, w_cx, 16'h0000} + {1'b0, w_cy} + 50'd32768;
    assign w_y_next  = r_first ? {i_sample, 16'h0000} : w_sum[47:16];
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_end     = i_last_sample ||
                       (w_cnt_inc == acrms_pkg::CNT_W'(acrms_pkg::MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 1'b1;
            r_cnt      <= '0;
            r_y        <= '0;
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_accept;
            if (w_accept) begin
                r_y <= w_y_next;
                if (w_end) begin
                    r_first <= 1'b1;
                    r_cnt   <= '0;
                end else begin
                    r_first <= 1'b0;
                    r_cnt   <= w_cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_x   <= i_sample;
            r_p1_end <= w_end;
            r_p1_n   <= w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            r_p2_xsq <= r_p1_x * r_p1_x;
            r_p2_ysq <= r_y * r_y;
            r_p2_end <= r_p1_end;
            r_p2_n   <= r_p1_n;
        end
    end

    assign w_ysq_tmp = {1'b0, r_p2_ysq} + (acrms_pkg::YSQ_W+1)'(64'd8388608);
    assign w_ysq_rnd = w_ysq_tmp[acrms_pkg::YSQ_W-1:24];
    assign n_s       = r_s + acrms_pkg::S_W'(r_p2_xsq);
    assign n_sy      = r_sy + acrms_pkg::SY_W'(w_ysq_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s  <= '0;
            r_sy <= '0;
        end else if (r_p2_valid) begin
            if (r_p2_end) begin
                r_s  <= '0;
                r_sy <= '0;
            end else begin
                r_s  <= n_s;
                r_sy <= n_sy;
            end
        end
    end

    assign o_q_push   = r_p2_valid && r_p2_end;
    assign o_q_data.s  = n_s;
    assign o_q_data.sy = n_sy;
    assign o_q_data.n  = r_p2_n;

endmodule

// File: rtl/acrms_run_fifo.sv
// ----------------------------------------------------------------------------
// AC RMS estimator run queue
// Short queue of finished run sums between the front end and the solver.
// ----------------------------------------------------------------------------
module acrms_run_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  acrms_pkg::t_run                 i_data,
    input  logic                            i_pop,
    output acrms_pkg::t_run                 o_data,
    output logic [acrms_pkg::QCNT_W-1:0]    o_count
);

    acrms_pkg::t_run                    r_mem [acrms_pkg::QDEPTH];
    logic [acrms_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [acrms_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [acrms_pkg::QCNT_W-1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: rtl/acrms_back.sv
// ----------------------------------------------------------------------------
// AC RMS estimator solver
// Per-run divide and square roots on a shared bit-serial unit, gain scaling,
// and the result register.
// ----------------------------------------------------------------------------
module acrms_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  acrms_pkg::t_run                     i_q_data,
    output logic                                o_q_pop,
    input  logic [acrms_pkg::GAIN_W-1:0]        i_gain,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic [acrms_pkg::OUT_W-1:0]         o_ac_rms,
    output logic [acrms_pkg::OUT_W-1:0]         o_total_rms,
    output logic [acrms_pkg::OUT_W-1:0]         o_dc_rms,
    output logic [acrms_pkg::CNT_OUT_W-1:0]     o_sample_total,
    output logic                                o_clamped,
    output logic                                o_saturated
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_GAIN  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [1:0] OP_TOTAL = 2'd0;
    localparam logic [1:0] OP_DC    = 2'd1;
    localparam logic [1:0] OP_AC    = 2'd2;

    localparam int CNT_W  = acrms_pkg::CNT_W;
    localparam int DV_W   = acrms_pkg::DV_W;
    localparam int RT_W   = acrms_pkg::RT_W;
    localparam int SY_W   = acrms_pkg::SY_W;
    localparam int OUT_W  = acrms_pkg::OUT_W;
    localparam int PROD_W = acrms_pkg::PROD_W;

    logic [2:0]                 r_state;
    logic [1:0]                 r_op;
    logic [acrms_pkg::CT_W-1:0] r_cnt;
    acrms_pkg::t_run            r_run;
    logic [DV_W-1:0]            r_dvd;
    logic [CNT_W-1:0]           r_rem;
    logic [RT_W-1:0]            r_root;
    logic [RT_W+1:0]            r_srem;
    logic [OUT_W-1:0]           r_total;
    logic [OUT_W-1:0]           r_dc;
    logic [OUT_W-1:0]           r_ac0;
    logic                       r_clamp;
    logic [PROD_W-1:0]          r_prod;

    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_ac;
    logic [OUT_W-1:0]           r_out_total;
    logic [OUT_W-1:0]           r_out_dc;
    logic [CNT_W-1:0]           r_out_n;
    logic                       r_out_clamp;
    logic                       r_out_sat;

    logic [SY_W-1:0]            w_s8;
    logic                       w_clamp;
    logic [SY_W-1:0]            w_diff;
    logic [DV_W-1:0]            w_operand;
    logic [CNT_W:0]             w_dshift;
    logic [CNT_W:0]             w_dsub;
    logic                       w_dge;
    logic [RT_W+1:0]            w_sshift;
    logic [RT_W+1:0]            w_trial;
    logic                       w_sge;
    logic [PROD_W:0]            w_rnd;
    logic [PROD_W-16:0]         w_ac_full;
    logic                       w_sat;
    logic                       w_out_free;

    assign w_s8    = {r_run.s, 8'h00};
    assign w_clamp = (r_run.sy > w_s8);
    assign w_diff  = w_clamp ? '0 : (w_s8 - r_run.sy);

    always_comb begin
        unique case (r_op)
            OP_TOTAL: w_operand = DV_W'({r_run.s, 16'h0000});
            OP_DC:    w_operand = DV_W'({r_run.sy, 8'h00});
            OP_AC:    w_operand = DV_W'({w_diff, 8'h00});
            default:  w_operand = '0;
        endcase
    end

    assign w_dshift = {r_rem, r_dvd[DV_W-1]};
    assign w_dsub   = w_dshift - {1'b0, r_run.n};
    assign w_dge    = (w_dshift >= {1'b0, r_run.n});

    assign w_sshift = {r_srem[RT_W-1:0], r_dvd[DV_W-1:DV_W-2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_sge    = (w_sshift >= w_trial);

    assign w_rnd     = {1'b0, r_prod} + (PROD_W+1)'(32768);
    assign w_ac_full = w_rnd[PROD_W:16];
    assign w_sat     = (w_ac_full > (PROD_W-15)'(acrms_pkg::OUT_MAX));

    assign w_out_free = !r_out_valid || i_pop;
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_TOTAL;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_op    <= OP_TOTAL;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_cnt == acrms_pkg::CT_W'(DV_W - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt == acrms_pkg::CT_W'(RT_W - 1)) begin
                        r_state <= ST_STORE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_STORE: begin
                    if (r_op == OP_AC) begin
                        r_state <= ST_GAIN;
                    end else begin
                        r_op    <= r_op + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_GAIN: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_run <= i_q_data;
        end
        if (r_state == ST_LOAD) begin
            r_dvd  <= w_operand;
            r_rem  <= '0;
            r_root <= '0;
            r_srem <= '0;
            if (r_op == OP_AC) begin
                r_clamp <= w_clamp;
            end
        end
        if (r_state == ST_DIV) begin
            r_dvd <= {r_dvd[DV_W-2:0], w_dge};
            r_rem <= w_dge ? w_dsub[CNT_W-1:0] : w_dshift[CNT_W-1:0];
        end
        if (r_state == ST_SQRT) begin
            r_dvd  <= {r_dvd[DV_W-3:0], 2'b00};
            r_srem <= w_sge ? (w_sshift - w_trial) : w_sshift;
            r_root <= {r_root[RT_W-2:0], w_sge};
        end
        if (r_state == ST_STORE) begin
            unique case (r_op)
                OP_TOTAL: r_total <= r_root[OUT_W-1:0];
                OP_DC:    r_dc    <= r_root[OUT_W-1:0];
                default:  r_ac0   <= r_root[OUT_W-1:0];
            endcase
        end
        if (r_state == ST_GAIN) begin
            r_prod <= r_ac0 * i_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_ac    <= w_sat ? acrms_pkg::OUT_MAX : w_ac_full[OUT_W-1:0];
            r_out_total <= r_total;
            r_out_dc    <= r_dc;
            r_out_n     <= r_run.n;
            r_out_clamp <= r_clamp;
            r_out_sat   <= w_sat;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_ac_rms       = r_out_ac;
    assign o_total_rms    = r_out_total;
    assign o_dc_rms       = r_out_dc;
    assign o_sample_total = acrms_pkg::CNT_OUT_W'(r_out_n);
    assign o_clamped      = r_out_clamp;
    assign o_saturated    = r_out_sat;

endmodule

// File: rtl/ac_rms_estimator_unit.sv
// ----------------------------------------------------------------------------
// AC RMS estimator
// Total, DC (smoothed) and gain-corrected AC RMS over runs of ADC samples.
// ----------------------------------------------------------------------------
// Input queue: a sample transfers when push is high and full is low; a sample
// with i_last_sample set, or the MAX_SAMPLES-th sample, closes the run.
// Samples are taken one per cycle while full is low, with no gaps needed.
// Result queue: one result per run, valid while empty is low, taken by pop.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_addr
// (0 smoothing coefficient, 1 AC gain); write only when idle.
// The delay from the closing sample to its result is set by the bit-serial
// divide and square root shared by the three roots.
// Up to four closed runs wait between the accumulator and the solver; full
// rises when those slots, counting run ends still in flight, are taken.
// A stalled result queue holds one result and then stops the solver; the
// sample side keeps running until the run queue fills.
// Reset clears all sums and queues and loads coefficient 1966 and gain 1.0.
// ----------------------------------------------------------------------------
module ac_rms_estimator_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [acrms_pkg::SMP_W-1:0]             i_sample,
    input  logic                                    i_last_sample,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [acrms_pkg::OUT_W-1:0]             o_ac_rms,
    output logic [acrms_pkg::OUT_W-1:0]             o_total_rms,
    output logic [acrms_pkg::OUT_W-1:0]             o_dc_rms,
    output logic [acrms_pkg::CNT_OUT_W-1:0]         o_sample_total,
    output logic                                    o_clamped,
    output logic                                    o_saturated,
    input  logic                                    i_cfg_wr_en,
    input  logic [acrms_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [acrms_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    logic [acrms_pkg::COEF_W-1:0]   r_coeff;
    logic [acrms_pkg::GAIN_W-1:0]   r_gain;

    logic                           w_q_push;
    logic                           w_q_pop;
    acrms_pkg::t_run                w_q_wdata;
    acrms_pkg::t_run                w_q_rdata;
    logic [acrms_pkg::QCNT_W-1:0]   w_q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= acrms_pkg::COEF_RESET;
            r_gain  <= acrms_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                acrms_pkg::REG_SMOOTHING_COEFF: r_coeff <= i_cfg_wdata[acrms_pkg::COEF_W-1:0];
                acrms_pkg::REG_AC_GAIN:         r_gain  <= i_cfg_wdata[acrms_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    acrms_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_coeff       (r_coeff),
        .i_q_count     (w_q_count),
        .o_full        (full),
        .o_q_push      (w_q_push),
        .o_q_data      (w_q_wdata)
    );

    acrms_run_fifo u_run_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_count (w_q_count)
    );

    acrms_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_count != '0),
        .i_q_data       (w_q_rdata),
        .o_q_pop        (w_q_pop),
        .i_gain         (r_gain),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_ac_rms       (o_ac_rms),
        .o_total_rms    (o_total_rms),
        .o_dc_rms       (o_dc_rms),
        .o_sample_total (o_sample_total),
        .o_clamped      (o_clamped),
        .o_saturated    (o_saturated)
    );

endmodule

// File: rtl/acrms_checker.sv
// ----------------------------------------------------------------------------
// AC RMS estimator port checker
// Assertions on the result port over time, bound to the top level.
// ----------------------------------------------------------------------------
module acrms_port_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    empty,
    input  logic                                    pop,
    input  logic [acrms_pkg::OUT_W-1:0]             o_ac_rms,
    input  logic [acrms_pkg::OUT_W-1:0]             o_total_rms,
    input  logic [acrms_pkg::OUT_W-1:0]             o_dc_rms,
    input  logic [acrms_pkg::CNT_OUT_W-1:0]         o_sample_total,
    input  logic                                    o_clamped,
    input  logic                                    o_saturated
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_ac_rms) && $stable(o_total_rms)
                              && $stable(o_dc_rms) && $stable(o_sample_total)))
        else $error("result changed while stalled");

    a_clamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_clamped) |-> (o_ac_rms == '0 && !o_saturated))
        else $error("clamped result with nonzero AC");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_saturated) |-> (o_ac_rms == acrms_pkg::OUT_MAX))
        else $error("saturated result below full scale");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_sample_total != '0 &&
                    o_sample_total <= acrms_pkg::CNT_OUT_W'(acrms_pkg::MAX_SAMPLES)))
        else $error("sample count out of range");

endmodule

bind ac_rms_estimator_unit acrms_port_checker u_acrms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_ac_rms       (o_ac_rms),
    .o_total_rms    (o_total_rms),
    .o_dc_rms       (o_dc_rms),
    .o_sample_total (o_sample_total),
    .o_clamped      (o_clamped),
    .o_saturated    (o_saturated)
);
